// ----- hdl/chce_pkg.sv -----
// Shared types, field layout and codes of the cubic Hermite curve evaluator.
package chce_pkg;

   localparam int DEF_MAX_POINTS = 64;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int COORD_BITS     = 32;

   localparam int FUNC_W     = 2;
   localparam int IDX_W      = 6;
   localparam int U_W        = 22;
   localparam int CNT_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 3 * COORD_BITS;

   localparam int IDX_LSB = 0;
   localparam int VX_LSB  = IDX_LSB + IDX_W;
   localparam int VY_LSB  = VX_LSB + COORD_BITS;
   localparam int VZ_LSB  = VY_LSB + COORD_BITS;
   localparam int U_LSB   = VZ_LSB + COORD_BITS;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_POINT   = 2'd0,
      FUNC_LOAD_TANGENT = 2'd1,
      FUNC_EVAL_POINT   = 2'd2,
      FUNC_EVAL_DERIV   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_BAD_PARAM = 2'd2
   } status_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [2:0] vec_type;
   // p0, p1, t0, t1 from index 0 up
   typedef vec_type [3:0] pts_type;

   typedef struct packed {
      logic       deriv;
      logic       blend;
      logic       last;
      status_type status;
   } ctl_type;

endpackage

// ----- hdl/chce_store.sv -----
// Vector table with one write port and two registered read ports.
module chce_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  chce_pkg::vec_type   wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output chce_pkg::vec_type   rd_data_a,
   output chce_pkg::vec_type   rd_data_b
);
   import chce_pkg::*;

   vec_type mem [DEPTH];
   vec_type rd_a_ff;
   vec_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hdl/chce_basis.sv -----
// Hermite basis weights: square, cube and weight stages for curve or derivative.
module chce_basis #(
   parameter int FRAC_BITS = 16,
   parameter int WGT_W     = FRAC_BITS + 4
) (
   input  logic                        clock,
   input  logic                        en1,
   input  logic                        en2,
   input  logic                        en3,
   input  logic [FRAC_BITS-1:0]        t_in,
   input  logic                        deriv2,
   output logic [3:0][WGT_W-1:0]       weight
);
   import chce_pkg::*;

   localparam int PROD_W = 2 * FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(1) << FRAC_BITS;

   logic [PROD_W-1:0]    sq_full;
   logic [PROD_W-1:0]    cube_full;
   logic [FRAC_BITS-1:0] t1_ff;
   logic [FRAC_BITS-1:0] s2_1_ff;
   logic [FRAC_BITS-1:0] t2_ff;
   logic [FRAC_BITS-1:0] s2_2_ff;
   logic [FRAC_BITS-1:0] s3_2_ff;
   logic signed [WGT_W-1:0] tw;
   logic signed [WGT_W-1:0] s2w;
   logic signed [WGT_W-1:0] s3w;
   logic signed [WGT_W-1:0] h00;
   logic signed [WGT_W-1:0] d00;
   logic [3:0][WGT_W-1:0] weight_in;
   logic [3:0][WGT_W-1:0] weight_ff;

   assign sq_full   = {FRAC_BITS'(0), t_in} * {FRAC_BITS'(0), t_in} + HALF_P;
   assign cube_full = {FRAC_BITS'(0), s2_1_ff} * {FRAC_BITS'(0), t1_ff} + HALF_P;

   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff   <= t_in;
         s2_1_ff <= sq_full[PROD_W-1:FRAC_BITS];
      end
      if (en2) begin
         t2_ff   <= t1_ff;
         s2_2_ff <= s2_1_ff;
         s3_2_ff <= cube_full[PROD_W-1:FRAC_BITS];
      end
      if (en3) begin
         weight_ff <= weight_in;
      end
   end

   always_comb begin
      tw  = $signed({{(WGT_W-FRAC_BITS){1'b0}}, t2_ff});
      s2w = $signed({{(WGT_W-FRAC_BITS){1'b0}}, s2_2_ff});
      s3w = $signed({{(WGT_W-FRAC_BITS){1'b0}}, s3_2_ff});
      h00 = (s3w <<< 1) - (s2w <<< 1) - s2w + ONE_W;
      d00 = (((s2w - tw) <<< 1) + (s2w - tw)) <<< 1;
      if (deriv2) begin
         weight_in[0] = d00;
         weight_in[1] = -d00;
         weight_in[2] = (s2w <<< 1) + s2w - (tw <<< 2) + ONE_W;
         weight_in[3] = (s2w <<< 1) + s2w - (tw <<< 1);
      end else begin
         weight_in[0] = h00;
         weight_in[1] = ONE_W - h00;
         weight_in[2] = s3w - (s2w <<< 1) + tw;
         weight_in[3] = s3w - s2w;
      end
   end

   assign weight = weight_ff;

endmodule

// ----- hdl/chce_blend.sv -----
// Blend stages: weighted products, rounded sum, saturation and result select.
module chce_blend #(
   parameter int FRAC_BITS = 16,
   parameter int WGT_W     = FRAC_BITS + 4
) (
   input  logic                   clock,
   input  logic                   en4,
   input  logic                   en5,
   input  chce_pkg::ctl_type      ctl_in,
   input  chce_pkg::pts_type      pts_in,
   input  logic [3:0][WGT_W-1:0]  weight,
   output chce_pkg::vec_type      rsp_vec,
   output chce_pkg::status_type   rsp_status
);
   import chce_pkg::*;

   localparam int PW = COORD_BITS + WGT_W;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] CMAX =
      {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN =
      {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   logic [2:0][3:0][PW-1:0] prod_in;
   logic [2:0][3:0][PW-1:0] prod_ff;
   ctl_type                 ctl4_ff;
   vec_type                 last4_ff;
   logic signed [SW-1:0]    sum_in [3];
   logic signed [SW-1:0]    rnd_in [3];
   vec_type                 sat_in;
   vec_type                 vec_in;
   vec_type                 vec_ff;
   status_type              status_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 4; k++) begin
            prod_in[j][k] = $signed(pts_in[k][j]) * $signed(weight[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         prod_ff  <= prod_in;
         ctl4_ff  <= ctl_in;
         last4_ff <= ctl_in.deriv ? pts_in[2] : pts_in[0];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_in[j] = SW'($signed(prod_ff[j][0])) + SW'($signed(prod_ff[j][1]))
                   + SW'($signed(prod_ff[j][2])) + SW'($signed(prod_ff[j][3]))
                   + HALF_S;
         rnd_in[j] = sum_in[j] >>> FRAC_BITS;
         if (rnd_in[j] > CMAX) begin
            sat_in[j] = CMAX[COORD_BITS-1:0];
         end else if (rnd_in[j] < CMIN) begin
            sat_in[j] = CMIN[COORD_BITS-1:0];
         end else begin
            sat_in[j] = rnd_in[j][COORD_BITS-1:0];
         end
      end
      if (ctl4_ff.blend) begin
         vec_in = sat_in;
      end else if (ctl4_ff.last) begin
         vec_in = last4_ff;
      end else begin
         vec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         vec_ff    <= vec_in;
         status_ff <= ctl4_ff.status;
      end
   end

   assign rsp_vec    = vec_ff;
   assign rsp_status = status_ff;

endmodule

// ----- hdl/cubic_hermite_curve_evaluator_core.sv -----
// Top level of the cubic Hermite curve evaluator: decode, tables and pipeline control.
//
// Requests arrive on req_ (tvalid/tready/tdata/tuser): tuser carries the
// operation, tdata the entry index, a vector and the curve parameter u.
// Loads write a point or tangent table entry; evaluations return the curve
// point or its derivative for u. Every request yields one response on rsp_,
// in request order, with the vector in tdata and the status in tuser.
// csr_wr_en/csr_wr_data set the number of control points; write it only
// while no request is in flight.
// Pipeline: five register stages. Throughput: one request per cycle while the
// receiver takes responses; the table read is a single registered stage.
// Reset clears all stage valid bits and sets the point count to two; the
// tables hold nothing defined until loaded. When the receiver stalls, each
// stage holds its request and bubbles close up; req_tready falls only when
// all five stages are full.
module cubic_hermite_curve_evaluator_core #(
   parameter int MAX_POINTS = chce_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = chce_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_index, vec_x, vec_y, vec_z, param_u, zero fill
   input  logic [chce_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func
   input  logic [chce_pkg::FUNC_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_x, out_y, out_z
   output logic [chce_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [chce_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [chce_pkg::CNT_W-1:0]       csr_wr_data
);
   import chce_pkg::*;

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNTV_W = $clog2(MAX_POINTS + 1);
   localparam int SEG_W  = U_W - FRAC_BITS;
   localparam int M1_W   = (CNTV_W > SEG_W) ? CNTV_W : SEG_W;
   localparam int M2_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int CMP_W  = ((M1_W > M2_W) ? M1_W : M2_W) + 1;
   localparam int WGT_W  = FRAC_BITS + 4;

   logic [CNT_W-1:0]     cnt_ff;
   logic [CMP_W-1:0]     cnt_c;
   logic [CMP_W-1:0]     n_c;
   logic [CMP_W-1:0]     n_m1;
   logic [CMP_W-1:0]     seg_c;
   logic [CMP_W-1:0]     idx_c;
   logic [FRAC_BITS-1:0] frac;
   logic [U_W-1:0]       param_u;
   func_type             fn;
   ctl_type              ctl0;
   logic                 idx_ok;
   logic                 accept;
   logic                 pt_we;
   logic                 tg_we;
   logic [ADDR_W-1:0]    rd_addr_a;
   logic [ADDR_W-1:0]    rd_addr_b;
   vec_type              wr_vec;
   vec_type              pt_a;
   vec_type              pt_b;
   vec_type              tg_a;
   vec_type              tg_b;
   logic [5:1]           valid_ff;
   logic [5:1]           valid_in;
   logic [5:1]           rdy;
   ctl_type              ctl1_ff;
   ctl_type              ctl2_ff;
   ctl_type              ctl3_ff;
   pts_type              pts2_ff;
   pts_type              pts3_ff;
   logic [3:0][WGT_W-1:0] weight;
   vec_type              rsp_vec;
   status_type           rsp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_RESET;
      end else if (csr_wr_en) begin
         cnt_ff <= csr_wr_data;
      end
   end

   assign cnt_c   = CMP_W'(cnt_ff);
   assign n_c     = (cnt_c < CMP_W'(2)) ? CMP_W'(2) :
                    (cnt_c > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : cnt_c;
   assign n_m1    = n_c - CMP_W'(1);
   assign param_u = req_tdata[U_LSB +: U_W];
   assign seg_c   = CMP_W'(param_u[U_W-1:FRAC_BITS]);
   assign frac    = param_u[FRAC_BITS-1:0];
   assign idx_c   = CMP_W'(req_tdata[IDX_LSB +: IDX_W]);
   assign idx_ok  = idx_c < n_c;
   assign fn      = func_type'(req_tuser);
   assign wr_vec  = {req_tdata[VZ_LSB +: COORD_BITS], req_tdata[VY_LSB +: COORD_BITS],
                     req_tdata[VX_LSB +: COORD_BITS]};

   always_comb begin
      ctl0 = '{deriv: 1'b0, blend: 1'b0, last: 1'b0, status: STATUS_OK};
      unique case (fn) inside
         FUNC_LOAD_POINT, FUNC_LOAD_TANGENT: begin
            if (!idx_ok) begin
               ctl0.status = STATUS_BAD_INDEX;
            end
         end
         FUNC_EVAL_POINT, FUNC_EVAL_DERIV: begin
            ctl0.deriv = (fn == FUNC_EVAL_DERIV);
            if (seg_c < n_m1) begin
               ctl0.blend = 1'b1;
            end else if (seg_c == n_m1 && frac == '0) begin
               ctl0.last = 1'b1;
            end else begin
               ctl0.status = STATUS_BAD_PARAM;
            end
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_tvalid && req_tready;
   assign pt_we     = accept && fn == FUNC_LOAD_POINT && idx_ok;
   assign tg_we     = accept && fn == FUNC_LOAD_TANGENT && idx_ok;
   assign rd_addr_a = seg_c[ADDR_W-1:0];
   assign rd_addr_b = rd_addr_a + ADDR_W'(1);

   chce_store #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_point_store (
      .clock     (clock),
      .wr_en     (pt_we),
      .wr_addr   (idx_c[ADDR_W-1:0]),
      .wr_data   (wr_vec),
      .rd_en     (rdy[1]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (pt_a),
      .rd_data_b (pt_b)
   );

   chce_store #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_tangent_store (
      .clock     (clock),
      .wr_en     (tg_we),
      .wr_addr   (idx_c[ADDR_W-1:0]),
      .wr_data   (wr_vec),
      .rd_en     (rdy[1]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (tg_a),
      .rd_data_b (tg_b)
   );

   // advance a stage when it is empty or the next one takes its request
   always_comb begin
      rdy[5] = !valid_ff[5] || rsp_tready;
      for (int k = 4; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[1] = rdy[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= 5; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ctl1_ff <= ctl0;
      end
      if (rdy[2]) begin
         ctl2_ff <= ctl1_ff;
         pts2_ff <= {tg_b, tg_a, pt_b, pt_a};
      end
      if (rdy[3]) begin
         ctl3_ff <= ctl2_ff;
         pts3_ff <= pts2_ff;
      end
   end

   chce_basis #(
      .FRAC_BITS (FRAC_BITS),
      .WGT_W     (WGT_W)
   ) u_basis (
      .clock  (clock),
      .en1    (rdy[1]),
      .en2    (rdy[2]),
      .en3    (rdy[3]),
      .t_in   (frac),
      .deriv2 (ctl2_ff.deriv),
      .weight (weight)
   );

   chce_blend #(
      .FRAC_BITS (FRAC_BITS),
      .WGT_W     (WGT_W)
   ) u_blend (
      .clock      (clock),
      .en4        (rdy[4]),
      .en5        (rdy[5]),
      .ctl_in     (ctl3_ff),
      .pts_in     (pts3_ff),
      .weight     (weight),
      .rsp_vec    (rsp_vec),
      .rsp_status (rsp_status)
   );

   assign req_tready = rdy[1];
   assign rsp_tvalid = valid_ff[5];
   assign rsp_tdata  = rsp_vec;
   assign rsp_tuser  = rsp_status;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("request taken while every stage is full and stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff[1])
      else $error("accepted request missing from first stage");

   a_reach_output: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && rdy[5] |=> rsp_tvalid)
      else $error("request lost between blend stages");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STATUS_OK |-> rsp_vec == '0)
      else $error("error response carries a nonzero vector");

   a_ctl_exclusive: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> !(ctl3_ff.blend && ctl3_ff.last)
                      && !((ctl3_ff.blend || ctl3_ff.last) && ctl3_ff.status != STATUS_OK))
      else $error("conflicting result selection in pipeline");

endmodule
